// File: design/pyr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pyr_pkg;

   localparam int MAX_HALVINGS = 11;
   // horizontal levels below this one are merged in the first front stage
   localparam int HSPLIT       = 6;
   localparam int LINE_DEPTH   = 2048;
   localparam int LINE_AW      = 11;
   localparam int DIM_W        = 12;
   localparam int LVL_W        = 4;
   localparam int PIX_W        = 32;
   localparam int QDEPTH       = 4;
   localparam int QPTR_W       = 2;
   localparam int QCNT_W       = 3;
   localparam int CSR_AW       = 2;

   localparam logic [CSR_AW-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_AW-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_AW-1:0] REG_MAX_WIDTH    = 2'd2;
   localparam logic [CSR_AW-1:0] REG_MAX_HEIGHT   = 2'd3;

   typedef struct packed {
      logic [LVL_W-1:0] k;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [DIM_W-1:0] sw;
      logic [DIM_W-1:0] sh;
   } frame_type;

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic [DIM_W-1:0] col;
      logic [LVL_W-1:0] vlev;
      logic             is_out;
      logic             last;
   } qent_type;

   // bytewise rounded pair average
   function automatic logic [PIX_W-1:0] merge_px(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
      logic [PIX_W-1:0] r;
      logic [6:0]       x;
      logic [6:0]       y;
      r = '0;
      for (int s = 0; s < 4; s++) begin
         x = a[8*s+1 +: 7];
         y = b[8*s+1 +: 7];
         r[8*s +: 8] = {1'b0, x} + {1'b0, y} + {7'd0, x[0] & y[0]};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: design/pyr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module pyr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: design/pyr_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pyr_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       restart,
   input  wire logic                       settled,
   input  wire pyr_pkg::frame_type         frame,
   input  wire logic [pyr_pkg::QCNT_W-1:0] q_count,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [pyr_pkg::PIX_W-1:0]  req_tdata,
   output logic                            push,
   output pyr_pkg::qent_type               push_ent
);

   logic [pyr_pkg::DIM_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [pyr_pkg::PIX_W-1:0] held_ff [pyr_pkg::MAX_HALVINGS];
   logic [pyr_pkg::PIX_W-1:0] held_wd [pyr_pkg::MAX_HALVINGS];
   logic [pyr_pkg::MAX_HALVINGS-1:0] held_we;

   logic                      s1_valid_ff, s1_valid_in;
   logic [pyr_pkg::PIX_W-1:0] s1_pix_ff, v1, v2;
   logic [pyr_pkg::DIM_W-1:0] s1_col_ff, s1_row_ff, m, r;
   logic [pyr_pkg::LVL_W-1:0] tv;
   logic                      st1, st2, run, accept_px, zero_dim;
   logic [pyr_pkg::DIM_W:0]   col_next, row_next;

   assign zero_dim   = (frame.width == '0) || (frame.height == '0);
   assign req_tready = settled &&
                       ({1'b0, q_count} + {3'd0, s1_valid_ff} < 4'(pyr_pkg::QDEPTH));
   assign accept_px  = req_tvalid && req_tready && !zero_dim;

   always_comb begin
      held_we = '0;
      for (int j = 0; j < pyr_pkg::MAX_HALVINGS; j++) begin
         held_wd[j] = '0;
      end
      // first stage: low horizontal levels on the incoming pixel
      v1  = req_tdata;
      st1 = 1'b0;
      for (int j = 0; j < pyr_pkg::HSPLIT; j++) begin
         if (!st1 && (pyr_pkg::LVL_W'(j) < frame.k)) begin
            if (!col_ff[j]) begin
               held_wd[j] = v1;
               held_we[j] = accept_px;
               st1        = 1'b1;
            end else begin
               v1 = pyr_pkg::merge_px(held_ff[j], v1);
            end
         end
      end
      // second stage: upper horizontal levels
      v2  = s1_pix_ff;
      st2 = 1'b0;
      for (int j = pyr_pkg::HSPLIT; j < pyr_pkg::MAX_HALVINGS; j++) begin
         if (!st2 && (pyr_pkg::LVL_W'(j) < frame.k)) begin
            if (!s1_col_ff[j]) begin
               held_wd[j] = v2;
               held_we[j] = s1_valid_ff;
               st2        = 1'b1;
            end else begin
               v2 = pyr_pkg::merge_px(held_ff[j], v2);
            end
         end
      end
      // run of low set row bits decides the vertical depth
      tv  = '0;
      run = 1'b1;
      for (int j = 0; j < pyr_pkg::MAX_HALVINGS; j++) begin
         if (run && (pyr_pkg::LVL_W'(j) < frame.k) && s1_row_ff[j]) begin
            tv = tv + 1'b1;
         end else begin
            run = 1'b0;
         end
      end
   end

   assign s1_valid_in = accept_px && !st1;
   assign m = s1_col_ff >> frame.k;
   assign r = s1_row_ff >> frame.k;

   assign push            = s1_valid_ff && !st2;
   assign push_ent.pix    = v2;
   assign push_ent.col    = m;
   assign push_ent.vlev   = tv;
   assign push_ent.is_out = (tv == frame.k);
   assign push_ent.last   = (m == frame.sw - 1'b1) && (r == frame.sh - 1'b1);

   assign col_next = {1'b0, col_ff} + 13'd1;
   assign row_next = {1'b0, row_ff} + 13'd1;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept_px) begin
         if (col_next >= {1'b0, frame.width}) begin
            col_in = '0;
            row_in = (row_next >= {1'b0, frame.height}) ? '0 : row_next[pyr_pkg::DIM_W-1:0];
         end else begin
            col_in = col_next[pyr_pkg::DIM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_px) begin
         s1_pix_ff <= v1;
         s1_col_ff <= col_ff;
         s1_row_ff <= row_ff;
      end
      for (int j = 0; j < pyr_pkg::MAX_HALVINGS; j++) begin
         if (held_we[j]) begin
            held_ff[j] <= held_wd[j];
         end
      end
   end

`ifndef SYNTH
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_ent.vlev <= frame.k))
      else $error("vertical depth beyond halving count");
`endif

endmodule
`default_nettype wire

// File: design/pyr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module pyr_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire pyr_pkg::qent_type          push_ent,
   input  wire logic                       pop,
   output logic                            head_valid,
   output pyr_pkg::qent_type               head,
   output logic [pyr_pkg::QCNT_W-1:0]      count
);

   pyr_pkg::qent_type         slot_ff [pyr_pkg::QDEPTH];
   logic [pyr_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [pyr_pkg::QCNT_W-1:0] count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_ent;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && (count_ff == pyr_pkg::QCNT_W'(pyr_pkg::QDEPTH))))
      else $error("queue overflow");
`endif

endmodule
`default_nettype wire

// File: design/pyr_back.sv
`timescale 1ns / 1ps
`default_nettype none
module pyr_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire pyr_pkg::frame_type        frame,
   input  wire logic                      head_valid,
   input  wire pyr_pkg::qent_type         head,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [pyr_pkg::PIX_W-1:0]      rsp_tdata,
   output logic                           rsp_tlast
);

   logic [pyr_pkg::LVL_W-1:0] lvl_ff, lvl_in;
   logic [pyr_pkg::DIM_W-1:0] base_ff, base_in, addr;
   logic [pyr_pkg::PIX_W-1:0] acc_ff, acc_in, cur, rd_data;
   logic                      rd_pend_ff, rd_pend_in, rd_en, wr_en, load, out_free;
   logic                      valid_ff, valid_in;

   assign out_free = !valid_ff || rsp_tready;
   assign addr     = base_ff + head.col;
   assign cur      = rd_pend_ff ? pyr_pkg::merge_px(rd_data, acc_ff) :
                     ((lvl_ff == '0) ? head.pix : acc_ff);

   always_comb begin
      lvl_in     = lvl_ff;
      base_in    = base_ff;
      acc_in     = acc_ff;
      rd_pend_in = 1'b0;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      load       = 1'b0;
      pop        = 1'b0;
      if (head_valid) begin
         if (lvl_ff < head.vlev) begin
            rd_en      = 1'b1;
            rd_pend_in = 1'b1;
            lvl_in     = lvl_ff + 1'b1;
            base_in    = base_ff + frame.sw;
            acc_in     = cur;
         end else if (head.is_out) begin
            if (out_free) begin
               load    = 1'b1;
               pop     = 1'b1;
               lvl_in  = '0;
               base_in = '0;
            end else begin
               acc_in = cur;
            end
         end else begin
            wr_en   = 1'b1;
            pop     = 1'b1;
            lvl_in  = '0;
            base_in = '0;
         end
      end
   end

   assign valid_in = load || (valid_ff && !rsp_tready);

   pyr_ram #(
      .WIDTH (pyr_pkg::PIX_W),
      .DEPTH (pyr_pkg::LINE_DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr[pyr_pkg::LINE_AW-1:0]),
      .wr_data (cur),
      .rd_en   (rd_en),
      .rd_addr (addr[pyr_pkg::LINE_AW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_ff     <= '0;
         base_ff    <= '0;
         rd_pend_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         lvl_ff     <= lvl_in;
         base_ff    <= base_in;
         rd_pend_ff <= rd_pend_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (load) begin
         rsp_tdata <= cur;
         rsp_tlast <= head.last;
      end
   end

   assign rsp_tvalid = valid_ff;

`ifndef SYNTH
   a_pend_level: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (lvl_ff != '0))
      else $error("read pending at level zero");
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      load |-> out_free)
      else $error("output loaded while held");
   a_rw_excl: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && (wr_en || load)))
      else $error("read and finish in one cycle");
`endif

endmodule
`default_nettype wire

// File: design/pyramid_halving_downscaler.sv
`timescale 1ns / 1ps
`default_nettype none
// pyramid halving downscaler: shrinks a raster image by 2^k in both directions
// req channel: one pixel per request, bytes 0..3 in tdata from the lowest bit
// rsp channel: one downscaled pixel per response, tlast on the final pixel
// csr port: image_width, image_height, max_width, max_height (indexes 0..3);
//   k is the smallest count of halvings that fits both maxima, at most 11
// a write restarts the frame; requests are held off after it until k and the scaled sizes settle
// throughput: one request per cycle sustained unless the queue is full or the frame is
//   settling; a finished block needs one line store read per set low row bit plus a
//   finishing step in the back end, and the front keeps taking requests meanwhile
// output path: the request completing a block is registered in the front stage, queued,
//   read once from the line store per vertical level, then loaded into the output register
// reset: registers return to 1, 1, 2048, 2048 and positions to zero; the
//   line store holds no meaning until written and needs no clearing
// a stalled receiver holds the output register, the back end stops popping, the
//   four-entry queue fills, then req_tready drops
module pyramid_halving_downscaler (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [31:0]                 req_tdata,   // chan0_in, chan1_in, chan2_in, chan3_in
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [31:0]                      rsp_tdata,   // chan0_out, chan1_out, chan2_out, chan3_out
   output logic                             rsp_tlast,   // last_pixel
   input  wire logic                        csr_we,
   input  wire logic [pyr_pkg::CSR_AW-1:0]  csr_addr,
   input  wire logic [pyr_pkg::DIM_W-1:0]   csr_wdata
);

   // configuration registers
   logic [pyr_pkg::DIM_W-1:0] width_ff, height_ff, maxw_ff, maxh_ff;
   logic [pyr_pkg::DIM_W-1:0] sw_ff, sh_ff;
   logic [pyr_pkg::LVL_W-1:0] k_ff, k_in;
   logic [1:0]                settle_ff, settle_in;
   pyr_pkg::frame_type        frame;

   // front to queue to back
   logic                       push, pop, head_valid;
   pyr_pkg::qent_type          push_ent, head;
   logic [pyr_pkg::QCNT_W-1:0] q_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 12'd1;
         height_ff <= 12'd1;
         maxw_ff   <= 12'd2048;
         maxh_ff   <= 12'd2048;
      end else if (csr_we) begin
         case (csr_addr)
            pyr_pkg::REG_IMAGE_WIDTH:  begin width_ff  <= csr_wdata; end
            pyr_pkg::REG_IMAGE_HEIGHT: begin height_ff <= csr_wdata; end
            pyr_pkg::REG_MAX_WIDTH:    begin maxw_ff   <= csr_wdata; end
            pyr_pkg::REG_MAX_HEIGHT:   begin maxh_ff   <= csr_wdata; end
            default:                   begin end
         endcase
      end
   end

   // every candidate count tested at once, smallest fitting one wins
   always_comb begin
      k_in = pyr_pkg::LVL_W'(pyr_pkg::MAX_HALVINGS);
      for (int c = pyr_pkg::MAX_HALVINGS - 1; c >= 0; c--) begin
         if (((width_ff >> c) <= maxw_ff) && ((height_ff >> c) <= maxh_ff)) begin
            k_in = pyr_pkg::LVL_W'(c);
         end
      end
   end

   // k is registered from the new sizes, and the scaled sizes are registered from k
   assign settle_in = csr_we ? 2'd2 : ((settle_ff != 2'd0) ? settle_ff - 2'd1 : 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= 2'd2;
      end else begin
         settle_ff <= settle_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff  <= k_in;
      sw_ff <= width_ff >> k_ff;
      sh_ff <= height_ff >> k_ff;
   end

   assign frame.k      = k_ff;
   assign frame.width  = width_ff;
   assign frame.height = height_ff;
   assign frame.sw     = sw_ff;
   assign frame.sh     = sh_ff;

   // accepts requests and does the horizontal merges
   pyr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_we),
      .settled    (settle_ff == 2'd0),
      .frame      (frame),
      .q_count    (q_count),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_ent   (push_ent)
   );

   pyr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ent   (push_ent),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head),
      .count      (q_count)
   );

   // vertical merges through the line store and the output register
   pyr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .frame      (frame),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for the pyramid halving downscaler
module testbench;

   // one expected downscaled pixel
   typedef struct {
      logic [31:0] pix;
      logic        last;
   } scaled_pixel_type;

   // scoreboard: tracks the frame the block should be in and predicts each output pixel
   class downscale_scoreboard;
      logic [11:0]      img_w, img_h, lim_w, lim_h;
      int unsigned      levels;
      int unsigned      col, row;
      logic [31:0]      held [pyr_pkg::MAX_HALVINGS];
      logic [31:0]      lines [pyr_pkg::LINE_DEPTH];
      scaled_pixel_type pending_pixels [$];
      int unsigned      mismatches;
      int unsigned      matched;

      function new();
         img_w = 12'd1;
         img_h = 12'd1;
         lim_w = 12'd2048;
         lim_h = 12'd2048;
         mismatches = 0;
         matched = 0;
         foreach (held[i]) held[i] = '0;
         foreach (lines[i]) lines[i] = '0;
         refit();
      endfunction

      // halving count from the current sizes; any write restarts the frame
      function void refit();
         int unsigned nw, nh;
         nw = img_w;
         nh = img_h;
         levels = 0;
         while ((nw > lim_w || nh > lim_h) && levels < pyr_pkg::MAX_HALVINGS) begin
            levels++;
            nw = nw >> 1;
            nh = nh >> 1;
         end
         col = 0;
         row = 0;
      endfunction

      function void write_reg(logic [pyr_pkg::CSR_AW-1:0] idx, logic [11:0] val);
         case (idx)
            pyr_pkg::REG_IMAGE_WIDTH:  img_w = val;
            pyr_pkg::REG_IMAGE_HEIGHT: img_h = val;
            pyr_pkg::REG_MAX_WIDTH:    lim_w = val;
            pyr_pkg::REG_MAX_HEIGHT:   lim_h = val;
            default:                   return;
         endcase
         refit();
      endfunction

      // rounded bytewise pair average
      function logic [31:0] pair_avg(logic [31:0] a, logic [31:0] b);
         logic [31:0] r;
         logic [7:0]  x, y;
         for (int s = 0; s < 4; s++) begin
            x = a[8*s +: 8] >> 1;
            y = b[8*s +: 8] >> 1;
            r[8*s +: 8] = x + y + (x & y & 8'd1);
         end
         return r;
      endfunction

      // an accepted request: advance positions, merge, maybe queue an output pixel
      function void note_request(logic [31:0] pix);
         int unsigned      x, y, sw, sh, m, idx;
         logic [31:0]      v;
         scaled_pixel_type e;
         if (img_w == 0 || img_h == 0) return;
         x = col;
         y = row;
         v = pix;
         col = x + 1;
         if (col >= img_w) begin
            col = 0;
            row = y + 1;
            if (row >= img_h) row = 0;
         end
         for (int j = 0; j < levels; j++) begin
            if (((x >> j) & 1) == 0) begin
               held[j] = v;
               return;
            end
            v = pair_avg(held[j], v);
         end
         sw = img_w >> levels;
         sh = img_h >> levels;
         m = x >> levels;
         for (int j = 0; j < levels; j++) begin
            idx = j * sw + m;
            if (((y >> j) & 1) == 0) begin
               if (idx < pyr_pkg::LINE_DEPTH) lines[idx] = v;
               return;
            end
            v = pair_avg(idx < pyr_pkg::LINE_DEPTH ? lines[idx] : 32'd0, v);
         end
         e.pix = v;
         e.last = (sw != 0 && sh != 0 && m == sw - 1 && (y >> levels) == sh - 1);
         pending_pixels.push_back(e);
      endfunction

      function void check_response(logic [31:0] pix, logic last);
         scaled_pixel_type e;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected pixel %h last %b", pix, last);
            return;
         end
         e = pending_pixels.pop_front();
         if (e.pix !== pix || e.last !== last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("pixel mismatch: expected %h last %b, got %h last %b",
                        e.pix, e.last, pix, last);
         end else begin
            matched++;
         end
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [31:0]                  req_tdata;    // chan0_in, chan1_in, chan2_in, chan3_in
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [31:0]                  rsp_tdata;    // chan0_out, chan1_out, chan2_out, chan3_out
   logic                         rsp_tlast;    // last_pixel
   logic                         csr_we;
   logic [pyr_pkg::CSR_AW-1:0]   csr_addr;
   logic [pyr_pkg::DIM_W-1:0]    csr_wdata;

   downscale_scoreboard sb;

   // idle pattern: 0 sender idles 22 / receiver 68, 1 the other way round, 2 no idling
   int                idle_mode;
   bit                hold_off_req;
   int unsigned       request_count;
   int unsigned       phase_count;

   pyramid_halving_downscaler u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard limit on the run time
   initial begin
      #(12 * 1500000);
      $display("FAILED: results differ");
      $finish;
   end

   // receiver: checks on each handshake, stalls at random, one long hold-off on request
   initial begin : receiver
      int unsigned hold_left;
      int          stall_pct;
      hold_left = 0;
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tlast);
         if (hold_off_req && hold_left == 0) hold_left = 400;
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            stall_pct = (idle_mode == 0) ? 68 : (idle_mode == 1) ? 22 : 0;
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // one request; the sender may idle first, at random
   task automatic send_pixel(logic [31:0] pix);
      int sender_pct;
      sender_pct = (idle_mode == 0) ? 22 : (idle_mode == 1) ? 68 : 0;
      while ($urandom_range(99) < sender_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      sb.note_request(pix);
      request_count++;
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // wait until every expected pixel is out, then give the pipeline time to drain
   task automatic drain();
      stop_sending();
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [pyr_pkg::CSR_AW-1:0] idx, logic [11:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   // new geometry then a run of pixels; n below w*h leaves a broken frame behind
   task automatic run_phase(int unsigned w, int unsigned h, int unsigned mw,
                            int unsigned mh, int unsigned n, bit rand_pix);
      drain();
      write_csr(pyr_pkg::REG_IMAGE_WIDTH, w[11:0]);
      write_csr(pyr_pkg::REG_IMAGE_HEIGHT, h[11:0]);
      write_csr(pyr_pkg::REG_MAX_WIDTH, mw[11:0]);
      write_csr(pyr_pkg::REG_MAX_HEIGHT, mh[11:0]);
      phase_count++;
      for (int unsigned i = 0; i < n; i++)
         send_pixel(rand_pix ? $urandom() : ((i & 1) ? 32'hFFFF_FFFF : 32'h0000_0000));
   endtask

   initial begin : stimulus
      int unsigned w, h, mw, mh, n;
      sb = new();
      idle_mode = 0;
      hold_off_req = 1'b0;
      request_count = 0;
      phase_count = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry: one pixel per frame, every pixel comes straight out with tlast
      send_pixel(32'h0000_0000);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h0101_0101);
      send_pixel(32'hFEFE_FEFE);
      send_pixel(32'h01FE_FF00);

      // one halving on a 4x4 image, extremes alternating to probe the rounding term
      run_phase(4, 4, 2, 2, 16, 1'b0);
      // zero height: every request swallowed without moving
      run_phase(8, 0, 2048, 2048, 6, 1'b1);
      // zero scaled height: nothing ever completes
      run_phase(16, 2, 1, 1, 8, 1'b1);
      // width beyond range drives the halving count into saturation
      run_phase(4095, 1, 1, 1, 120, 1'b1);
      // start of the widest line at no halving: every request is an output pixel
      run_phase(2048, 1, 2048, 1, 80, 1'b1);

      // random geometries, mostly whole frames, a few broken ones
      for (int p = 0; p < 20; p++) begin
         idle_mode = (p < 7) ? 0 : (p < 14) ? 1 : 2;
         w  = ($urandom_range(9) == 0) ? $urandom_range(64, 1) : $urandom_range(16, 1);
         h  = $urandom_range(8, 1);
         mw = $urandom_range(w, 1);
         mh = ($urandom_range(3) == 0) ? 2048 : $urandom_range(h, 1);
         n  = w * h * $urandom_range(2, 1);
         if (n > 120) n = w * h;
         if ($urandom_range(7) == 0) n = $urandom_range(w * h, 1);
         run_phase(w, h, mw, mh, n, 1'b1);
      end

      // long receiver hold-off with the sender pushing: the block must stall its input
      idle_mode = 2;
      drain();
      write_csr(pyr_pkg::REG_IMAGE_WIDTH, 12'd32);
      write_csr(pyr_pkg::REG_IMAGE_HEIGHT, 12'd8);
      write_csr(pyr_pkg::REG_MAX_WIDTH, 12'd32);
      write_csr(pyr_pkg::REG_MAX_HEIGHT, 12'd8);
      hold_off_req <= 1'b1;
      @(posedge clock);
      hold_off_req <= 1'b0;
      for (int i = 0; i < 256; i++) send_pixel($urandom());

      drain();
      $display("covered %0d requests over %0d geometries, %0d pixels checked",
               request_count, phase_count, sb.matched);
      $display("including zero sizes, saturated halving and a long output stall");
      if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// File: pyramid_halving_downscaler.f
design/pyr_pkg.sv
design/pyr_ram.sv
design/pyr_front.sv
design/pyr_queue.sv
design/pyr_back.sv
design/pyramid_halving_downscaler.sv
tb/sv/testbench.sv
